// ===== rtl/ordf_pkg.sv =====
// Shared types and constants for the object record deframer.
// No dependencies; used by every module in rtl/.
package ordf_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned LenW   = 16;
   localparam int unsigned StatW  = 2;
   localparam int unsigned TdataW = 48;
   localparam int unsigned TuserW = 4;

   localparam logic [LenW-1:0] LimitReset = 16'h2000;

   // Record status codes, meaningful on the final transfer of a record.
   localparam logic [StatW-1:0] StOk      = 2'd0;
   localparam logic [StatW-1:0] StBadSum  = 2'd1;
   localparam logic [StatW-1:0] StTooLong = 2'd2;

   typedef enum logic [3:0] {
      PH_TYPE   = 4'b0001,
      PH_LEN_LO = 4'b0010,
      PH_LEN_HI = 4'b0100,
      PH_BODY   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [ByteW-1:0] record_type;
      logic [ByteW-1:0] content_byte;
      logic [LenW-1:0]  byte_offset;
      logic [LenW-1:0]  record_length;
      logic             has_data;
      logic             is_last;
      logic [StatW-1:0] status;
   } result_type;

endpackage

// ===== rtl/object_record_deframer_unit.sv =====
// Top level of the object record deframer: length limit register, parser, result register.
// Depends on ordf_pkg, ordf_parser and ordf_out_reg.
//
//  channel | direction | payload
//  --------+-----------+--------------------------------------------------
//  req_    | in        | tdata[7:0] stream_byte
//  rsp_    | out       | tdata record_type/content_byte/offset/length,
//          |           | tlast is_last, tuser ext_index/has_data/status
//  csr_    | in        | csr_data[15:0] length_limit
//
// One stream byte per cycle sustained while rsp_ does not stall. A byte is
// held in the input register, then the parser updates its state and loads
// the result register, from which the result is offered.
// Reset (synchronous) returns the parser to waiting for a type byte and sets
// length_limit to 0x2000. A stalled rsp_ holds the result register; the input
// register keeps one byte, so req_tready drops only while both are full.
module object_record_deframer_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ordf_pkg::ByteW-1:0]    req_tdata,   // [7:0] stream_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [7:0] record_type, [15:8] content_byte, [31:16] byte_offset,
   // [47:32] record_length
   output logic [ordf_pkg::TdataW-1:0]   rsp_tdata,
   output logic                          rsp_tlast,   // is_last
   // [0] extended_index, [1] has_data, [3:2] status
   output logic [ordf_pkg::TuserW-1:0]   rsp_tuser,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ordf_pkg::LenW-1:0]     csr_data     // length_limit
);

   logic [ordf_pkg::LenW-1:0] limit_ff;
   logic                      out_free;
   logic                      res_fire;
   ordf_pkg::result_type      res;

   // register writes are to land only while idle; not enforced here, so take them every cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ordf_pkg::LimitReset;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   ordf_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .length_limit (limit_ff),
      .out_free     (out_free),
      .res_fire     (res_fire),
      .res          (res)
   );

   ordf_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res_fire   (res_fire),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/ordf_parser.sv =====
// Input byte register plus record parser state and per-byte result logic.
// Depends on ordf_pkg.
module ordf_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ordf_pkg::ByteW-1:0]    req_tdata,
   input  logic [ordf_pkg::LenW-1:0]     length_limit,
   input  logic                          out_free,
   output logic                          res_fire,
   output ordf_pkg::result_type          res
);

   logic                       in_valid_ff, in_valid_in;
   logic [ordf_pkg::ByteW-1:0] in_byte_ff;
   ordf_pkg::phase_type        phase_ff, phase_in;
   logic [ordf_pkg::ByteW-1:0] type_ff, type_in;
   logic [ordf_pkg::LenW-1:0]  length_ff, length_in;
   logic [ordf_pkg::LenW-1:0]  count_ff, count_in;
   logic [ordf_pkg::ByteW-1:0] sum_ff, sum_in;
   logic                       too_long_ff, too_long_in;
   logic                       advance;
   logic                       res_valid;
   logic [ordf_pkg::ByteW-1:0] sum_add;
   logic [ordf_pkg::LenW:0]    count_next;
   logic                       last;
   logic [ordf_pkg::StatW-1:0] fin_status;

   // one byte moves through the parser whenever the result slot can take it
   assign advance     = in_valid_ff && out_free;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign res_fire    = advance && res_valid;

   assign sum_add    = sum_ff + in_byte_ff;
   assign count_next = {1'b0, count_ff} + 17'd1;
   assign last       = count_next >= {1'b0, length_ff};

   always_comb begin
      phase_in    = phase_ff;
      type_in     = type_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      too_long_in = too_long_ff;
      res_valid   = 1'b0;
      fin_status  = ordf_pkg::StOk;
      res.record_type   = type_ff;
      res.content_byte  = in_byte_ff;
      res.byte_offset   = count_ff;
      res.record_length = length_ff;
      res.has_data      = 1'b1;
      res.is_last       = 1'b0;
      res.status        = ordf_pkg::StOk;
      unique case (phase_ff)
         ordf_pkg::PH_TYPE: begin
            type_in     = in_byte_ff;
            length_in   = '0;
            sum_in      = in_byte_ff;
            count_in    = '0;
            too_long_in = 1'b0;
            phase_in    = ordf_pkg::PH_LEN_LO;
         end
         ordf_pkg::PH_LEN_LO: begin
            length_in = {{(ordf_pkg::LenW-ordf_pkg::ByteW){1'b0}}, in_byte_ff};
            sum_in    = sum_add;
            phase_in  = ordf_pkg::PH_LEN_HI;
         end
         ordf_pkg::PH_LEN_HI: begin
            length_in   = {in_byte_ff, length_ff[ordf_pkg::ByteW-1:0]};
            sum_in      = sum_add;
            too_long_in = length_in >= length_limit;
            count_in    = '0;
            if (too_long_in) begin
               fin_status = ordf_pkg::StTooLong;
            end else if (sum_add != '0) begin
               fin_status = ordf_pkg::StBadSum;
            end
            // empty record: one data-less closing transfer
            res.record_length = length_in;
            res.content_byte  = '0;
            res.byte_offset   = '0;
            res.has_data      = 1'b0;
            res.is_last       = 1'b1;
            res.status        = fin_status;
            if (length_in == '0) begin
               res_valid = 1'b1;
               phase_in  = ordf_pkg::PH_TYPE;
            end else begin
               phase_in  = ordf_pkg::PH_BODY;
            end
         end
         ordf_pkg::PH_BODY: begin
            sum_in   = sum_add;
            count_in = count_next[ordf_pkg::LenW-1:0];
            if (too_long_ff) begin
               fin_status = ordf_pkg::StTooLong;
            end else if (sum_add != '0) begin
               fin_status = ordf_pkg::StBadSum;
            end
            if (last) begin
               res_valid   = 1'b1;
               res.is_last = 1'b1;
               res.status  = fin_status;
               phase_in    = ordf_pkg::PH_TYPE;
            end else begin
               // too-long content is swallowed until the final byte
               res_valid = !too_long_ff;
            end
         end
         default: begin
            phase_in = ordf_pkg::PH_TYPE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= ordf_pkg::PH_TYPE;
         type_ff     <= '0;
         length_ff   <= '0;
         count_ff    <= '0;
         sum_ff      <= '0;
         too_long_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            phase_ff    <= phase_in;
            type_ff     <= type_in;
            length_ff   <= length_in;
            count_ff    <= count_in;
            sum_ff      <= sum_in;
            too_long_ff <= too_long_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

endmodule

// ===== rtl/ordf_out_reg.sv =====
// Result register driving the rsp_ stream; packs tdata, tuser and tlast.
// Depends on ordf_pkg.
module ordf_out_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          res_fire,
   input  ordf_pkg::result_type          res,
   output logic                          out_free,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ordf_pkg::TdataW-1:0]   rsp_tdata,
   output logic                          rsp_tlast,
   output logic [ordf_pkg::TuserW-1:0]   rsp_tuser
);

   logic                 valid_ff, valid_in;
   ordf_pkg::result_type res_ff;

   assign out_free = !valid_ff || rsp_tready;
   assign valid_in = res_fire || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_fire) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {res_ff.record_length, res_ff.byte_offset,
                        res_ff.content_byte, res_ff.record_type};
   assign rsp_tlast  = res_ff.is_last;
   assign rsp_tuser  = {res_ff.status, res_ff.has_data, res_ff.record_type[0]};

endmodule
